// ===== src/kht_pkg.sv =====
package kht_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int KEY_W       = 32;
  localparam int POS_W       = 32;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 48;
  localparam int ADDR_W      = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);
  localparam logic [2:0]        PROBE_STRIDE = 3'd5;
  localparam logic [31:0]       HASH_MUL = 32'd2057;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_SET    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_H1,
    S_H2,
    S_H3,
    S_H4,
    S_MOD,
    S_RD,
    S_CHK,
    S_OUT
  } state_t;

  localparam logic [ADDR_W-1:0] REG_TABLE_SIZE = '0;

endpackage

// ===== src/kmer_hash_table_top.sv =====
// Open-addressed hash table of 32-bit k-mer keys with 4096 slots. Each input item carries a
// command (insert, lookup, set start position, clear all start positions), a key and a start
// position; each item gives exactly one result item. The home slot is the mixed key times
// the key, modulo the table size (table_size, with 0 read as 1 and above 4096 as 4096), and
// probing steps by 5 slots with wrap, giving up after as many slots as the table size. An
// insert, lookup or set runs through hash states S_H1 to S_H4, the bit-serial modulo unit
// on the 32-bit product, a read state and a check state per probed slot, and S_OUT, which
// loads the output register once an earlier result has gone out. It then goes idle, and
// only then takes its next item. Clear all sweeps the start memory, one slot a cycle; after
// reset both memories are cleared before the first item, while table_size can be written.
module kmer_hash_table_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [1:0] command, [33:2] key, [65:34] start_in
  input  logic [kht_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [1:0] status, [13:2] slot_index, [45:14] start_out, [46] start_valid
  output logic [kht_pkg::OUT_W-1:0] out_tdata,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kht_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import kht_pkg::*;

  logic [KEY_W:0] kmem [TABLE_DEPTH];
  logic [POS_W:0] smem [TABLE_DEPTH];

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   table_size_r, table_size_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [POS_W-1:0]    start_r, start_nxt;
  logic [SIZE_W-1:0]   s_r, s_nxt;
  logic [2:0]          stride_r, stride_nxt;
  logic [31:0]         h_r, h_nxt;
  logic [31:0]         p_r, p_nxt;
  logic [SIZE_W-1:0]   rem_r, rem_nxt;
  logic [4:0]          bit_r, bit_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SIZE_W-1:0]   n_r, n_nxt;
  logic [KEY_W:0]      kq_r;
  logic [POS_W:0]      sq_r;

  status_t             res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic [POS_W-1:0]    res_start_r, res_start_nxt;
  logic                res_sval_r, res_sval_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_slot_r, out_slot_nxt;
  logic [POS_W-1:0]    out_start_r, out_start_nxt;
  logic                out_sval_r, out_sval_nxt;

  logic                kwe, swe;
  logic [IDX_W-1:0]    waddr;
  logic [KEY_W:0]      kwd;
  logic [POS_W:0]      swd;

  logic                cfg_wr;
  logic [SIZE_W-1:0]   in_size;
  logic [SIZE_W-1:0]   eff_size;
  logic [2:0]          eff_stride;
  logic [31:0]         mix_a, mix_b, mix_c;
  logic [SIZE_W:0]     rem_sh;
  logic [SIZE_W-1:0]   idx_sum;
  logic                last_clr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == 1'b0);
  assign prdata = (paddr[ADDR_W-1] == REG_TABLE_SIZE[ADDR_W-1]) ?
                  {{(32-SIZE_W){1'b0}}, table_size_r} : 32'd0;
  assign table_size_nxt = cfg_wr ? pwdata[SIZE_W-1:0] : table_size_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_sval_r, out_start_r, out_slot_r, out_status_r};

  assign last_clr = (clr_r == IDX_W'(TABLE_DEPTH - 1));

  always_comb begin
    in_size = table_size_r;
    if (in_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (in_size > SIZE_W'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = in_size;
    end
    if (eff_size > SIZE_W'(PROBE_STRIDE)) begin
      eff_stride = PROBE_STRIDE;
    end else begin
      unique case (eff_size[2:0])
        3'd2:    eff_stride = 3'd1;
        3'd3:    eff_stride = 3'd2;
        3'd4:    eff_stride = 3'd1;
        default: eff_stride = 3'd0;
      endcase
    end
  end

  assign mix_a   = ~key_r + (key_r << 15);
  assign mix_b   = h_r + (h_r << 2);
  assign mix_c   = h_r * HASH_MUL;
  assign rem_sh  = {rem_r, p_r[31]};
  assign idx_sum = {1'b0, idx_r} + SIZE_W'(stride_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    start_nxt      = start_r;
    s_nxt          = s_r;
    stride_nxt     = stride_r;
    h_nxt          = h_r;
    p_nxt          = p_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_start_nxt  = res_start_r;
    res_sval_nxt   = res_sval_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_start_nxt  = out_start_r;
    out_sval_nxt   = out_sval_r;
    kwe            = 1'b0;
    swe            = 1'b0;
    waddr          = idx_r;
    kwd            = '0;
    swd            = '0;

    unique case (state_r)
      S_INIT: begin
        kwe     = 1'b1;
        swe     = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (last_clr) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = cmd_t'(in_tdata[1:0]);
          key_nxt        = in_tdata[33:2];
          start_nxt      = in_tdata[65:34];
          s_nxt          = eff_size;
          stride_nxt     = eff_stride;
          res_status_nxt = STAT_OK;
          res_slot_nxt   = '0;
          res_start_nxt  = '0;
          res_sval_nxt   = 1'b0;
          if (cmd_t'(in_tdata[1:0]) == CMD_CLEAR) begin
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_H1;
          end
        end
      end
      S_CLR: begin
        swe     = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (last_clr) begin
          state_nxt = S_OUT;
        end
      end
      S_H1: begin
        h_nxt     = mix_a ^ (mix_a >> 12);
        state_nxt = S_H2;
      end
      S_H2: begin
        h_nxt     = mix_b ^ (mix_b >> 4);
        state_nxt = S_H3;
      end
      S_H3: begin
        h_nxt     = mix_c ^ (mix_c >> 16);
        state_nxt = S_H4;
      end
      S_H4: begin
        p_nxt     = h_r * key_r;
        rem_nxt   = '0;
        bit_nxt   = '0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (rem_sh >= {1'b0, s_r}) begin
          rem_nxt = SIZE_W'(rem_sh - {1'b0, s_r});
        end else begin
          rem_nxt = rem_sh[SIZE_W-1:0];
        end
        p_nxt   = p_r << 1;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 5'd31) begin
          idx_nxt   = rem_nxt[IDX_W-1:0];
          n_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_OUT;
        if (!kq_r[KEY_W]) begin
          if (cmd_r == CMD_INSERT) begin
            kwe          = 1'b1;
            kwd          = {1'b1, key_r};
            swe          = 1'b1;
            res_slot_nxt = idx_r;
          end else begin
            res_status_nxt = STAT_NOTFOUND;
          end
        end else if (cmd_r != CMD_INSERT && kq_r[KEY_W-1:0] == key_r) begin
          res_slot_nxt = idx_r;
          if (cmd_r == CMD_SET) begin
            swe           = 1'b1;
            swd           = {1'b1, start_r};
            res_start_nxt = start_r;
            res_sval_nxt  = 1'b1;
          end else begin
            res_start_nxt = sq_r[POS_W] ? sq_r[POS_W-1:0] : '0;
            res_sval_nxt  = sq_r[POS_W];
          end
        end else if (n_r == s_r - 1'b1) begin
          res_status_nxt = (cmd_r == CMD_INSERT) ? STAT_FULL : STAT_NOTFOUND;
        end else begin
          if (idx_sum >= s_r) begin
            idx_nxt = IDX_W'(idx_sum - s_r);
          end else begin
            idx_nxt = idx_sum[IDX_W-1:0];
          end
          n_nxt     = n_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_start_nxt  = res_start_r;
          out_sval_nxt   = res_sval_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[waddr] <= kwd;
    end
    if (swe) begin
      smem[waddr] <= swd;
    end
    kq_r <= kmem[idx_r];
    sq_r <= smem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      clr_r        <= '0;
      table_size_r <= SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      table_size_r <= table_size_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    start_r      <= start_nxt;
    s_r          <= s_nxt;
    stride_r     <= stride_nxt;
    h_r          <= h_nxt;
    p_r          <= p_nxt;
    rem_r        <= rem_nxt;
    bit_r        <= bit_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_start_r  <= res_start_nxt;
    res_sval_r   <= res_sval_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_start_r  <= out_start_nxt;
    out_sval_r   <= out_sval_nxt;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import kht_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PROBE_STEP  = 5;

  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] start;
    logic [31:0] key;
    cmd_t        cmd;
  } cmd_item_t;

  typedef struct packed {
    logic        pad;
    logic        start_valid;
    logic [31:0] start_out;
    logic [11:0] slot_index;
    status_t     status;
  } reply_t;

  typedef enum logic [1:0] {
    WALK_HIT,
    WALK_EMPTY,
    WALK_EXHAUSTED
  } walk_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // [1:0] command, [33:2] key, [65:34] start_in
  logic [IN_W-1:0]    in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // [1:0] status, [13:2] slot_index, [45:14] start_out, [46] start_valid
  logic [OUT_W-1:0]   out_tdata;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  kmer_hash_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  logic [SIZE_W-1:0] tbl_size = SIZE_RESET;
  bit                tbl_used    [TABLE_DEPTH];
  logic [31:0]       tbl_key     [TABLE_DEPTH];
  logic [31:0]       tbl_pos     [TABLE_DEPTH];
  bit                tbl_pos_set [TABLE_DEPTH];

  cmd_item_t   cmd_backlog[$];
  reply_t      due_replies[$];
  logic [31:0] seen_keys[$];

  cmd_item_t   cur_item = '0;
  bit          in_live = 1'b0;
  bit          in_acc = 1'b0;
  bit          out_acc = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_wait = 0;
  int unsigned out_calm = 0;
  int unsigned items_taken = 0;
  int unsigned cycles = 0;
  int          errors = 0;

  function automatic logic [31:0] wang_mix(input logic [31:0] v);
    logic [31:0] k;
    k = ~v + (v << 15);
    k = k ^ (k >> 12);
    k = k + (k << 2);
    k = k ^ (k >> 4);
    k = k * 32'd2057;
    k = k ^ (k >> 16);
    return k;
  endfunction

  function automatic walk_t walk_probe(input logic [31:0] key, input bit want_empty,
                                       output int unsigned where);
    int unsigned span;
    int unsigned idx;
    logic [31:0] prod;
    span = (tbl_size == 0) ? 1 : ((tbl_size > TABLE_DEPTH) ? TABLE_DEPTH : tbl_size);
    prod = wang_mix(key) * key;
    idx = prod % span;
    where = 0;
    for (int unsigned n = 0; n < span; n++) begin
      if (!tbl_used[idx]) begin
        where = idx;
        return WALK_EMPTY;
      end
      if (!want_empty && tbl_key[idx] == key) begin
        where = idx;
        return WALK_HIT;
      end
      idx = (idx + PROBE_STEP) % span;
    end
    return WALK_EXHAUSTED;
  endfunction

  function automatic reply_t table_apply(input cmd_item_t it);
    reply_t      r;
    int unsigned where;
    walk_t       hit;
    r = '0;
    case (it.cmd)
      CMD_INSERT: begin
        hit = walk_probe(it.key, 1'b1, where);
        if (hit == WALK_EMPTY) begin
          tbl_used[where] = 1'b1;
          tbl_key[where] = it.key;
          tbl_pos_set[where] = 1'b0;
          r.slot_index = where[11:0];
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_LOOKUP, CMD_SET: begin
        hit = walk_probe(it.key, 1'b0, where);
        if (hit == WALK_HIT) begin
          if (it.cmd == CMD_SET) begin
            tbl_pos[where] = it.start;
            tbl_pos_set[where] = 1'b1;
          end
          r.slot_index = where[11:0];
          if (tbl_pos_set[where]) begin
            r.start_out = tbl_pos[where];
            r.start_valid = 1'b1;
          end
        end else begin
          r.status = STAT_NOTFOUND;
        end
      end
      default: begin
        foreach (tbl_pos_set[i]) tbl_pos_set[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(input cmd_t c, input logic [31:0] k,
                                    input logic [31:0] s);
    cmd_item_t it;
    it = '0;
    it.cmd = c;
    it.key = k;
    it.start = s;
    if (c == CMD_INSERT) seen_keys.push_back(k);
    cmd_backlog.push_back(it);
  endfunction

  // mostly known keys so that lookups and sets hit; fresh keys act as noise
  function automatic cmd_item_t random_item();
    cmd_item_t   it;
    int unsigned roll;
    it = '0;
    it.key = $urandom;
    it.start = $urandom;
    roll = $urandom_range(0, 99);
    if (roll == 0) begin
      it.cmd = CMD_CLEAR;
    end else if (roll < 36) begin
      it.cmd = CMD_INSERT;
      if (seen_keys.size() > 0 && $urandom_range(0, 3) == 0)
        it.key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
      else
        seen_keys.push_back(it.key);
    end else begin
      it.cmd = (roll < 66) ? CMD_LOOKUP : CMD_SET;
      if (seen_keys.size() > 0 && $urandom_range(0, 6) != 0)
        it.key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    end
    return it;
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    in_acc = rst_n && in_tvalid && in_tready;
    out_acc = rst_n && out_tvalid && out_tready;
    if (out_acc) begin
      got = out_tdata;
      if (due_replies.size() == 0) begin
        $error("unexpected result item: %h", out_tdata);
        errors++;
      end else begin
        want = due_replies.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
          errors++;
        end
        if (got.start_out !== want.start_out) begin
          $error("start_out: expected %h, got %h", want.start_out, got.start_out);
          errors++;
        end
        if (got.start_valid !== want.start_valid) begin
          $error("start_valid: expected %0d, got %0d", want.start_valid, got.start_valid);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (in_acc) begin
      due_replies.push_back(table_apply(cur_item));
      items_taken++;
      in_live = 1'b0;
      if (in_calm > 0) begin
        in_calm--;
        in_gap = 0;
      end else begin
        in_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(10, 40);
      end
    end
    if (rst_n && !in_live) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (cmd_backlog.size() > 0) begin
        cur_item = cmd_backlog.pop_front();
        in_live = 1'b1;
      end
    end
    in_tvalid <= in_live;
    in_tdata <= cur_item;
  end

  always @(negedge clk) begin
    if (out_acc) begin
      if (out_calm > 0) begin
        out_calm--;
        out_wait = 0;
      end else begin
        out_wait = $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(10, 40);
      end
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_tready <= !long_hold && out_wait == 0;
  end

  // hold off the result side long enough for the block to back up its input
  initial begin
    while (items_taken < 500) @(posedge clk);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (3000) @(negedge clk);
    long_hold <= 1'b0;
  end

  task automatic wait_idle();
    while (cmd_backlog.size() > 0 || in_live || due_replies.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [12:0] size);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_TABLE_SIZE;
    pwdata <= {19'($urandom), size};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tbl_size = size;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(input logic [12:0] size, input int count);
    wait_idle();
    write_size(size);
    repeat (count) cmd_backlog.push_back(random_item());
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // single slot: fill it, overflow it, set and clear its start position
    write_size(13'd1);
    queue_cmd(CMD_INSERT, 32'h0000_0000, 32'h0);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    queue_cmd(CMD_SET,    32'h0000_0000, 32'hFFFF_FFFF);
    queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
    queue_cmd(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
    queue_cmd(CMD_SET,    32'hFFFF_FFFF, 32'h0);

    // zero size acts as one slot
    wait_idle();
    write_size(13'd0);
    queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
    queue_cmd(CMD_INSERT, 32'h1234_5678, 32'h0);

    // oversize acts as full depth; earlier contents stay
    wait_idle();
    write_size(13'h1FFF);
    queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    queue_cmd(CMD_INSERT, 32'hAAAA_AAAA, 32'h0);
    queue_cmd(CMD_INSERT, 32'h5555_5555, 32'h0);
    queue_cmd(CMD_INSERT, 32'h5555_5555, 32'hFFFF_FFFF);
    queue_cmd(CMD_LOOKUP, 32'h5555_5555, 32'h0);
    queue_cmd(CMD_SET,    32'hAAAA_AAAA, 32'h5555_5555);
    queue_cmd(CMD_SET,    32'hFFFF_FFFF, 32'hAAAA_AAAA);
    queue_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    queue_cmd(CMD_LOOKUP, 32'h0F0F_0F0F, 32'h0);
    queue_cmd(CMD_INSERT, 32'h0000_0000, 32'h0);

    run_phase(13'd4096, 300);
    run_phase(13'd7, 60);
    run_phase(13'd10, 60);
    run_phase(13'd300, 250);
    run_phase(13'd2, 40);
    run_phase(13'd4095, 150);
    run_phase(13'd1, 30);
    run_phase(13'h1FFF, 150);

    wait_idle();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
